// ===== rtl/gtg_pkg.sv =====
// shared widths, constants and types of the go-to-goal controller
// no dependencies; imported by every module of the block
`default_nettype none

package gtg_pkg;

   localparam int POS_W    = 16;
   localparam int YAW_W    = 15;
   localparam int GAIN_W   = 12;
   localparam int DLIM_W   = 16;
   localparam int ALIM_W   = 14;
   localparam int DIFF_W   = POS_W + 1;
   localparam int ERR_W    = 15;
   localparam int SQ_W     = 32;
   localparam int ROOT_W   = 17;
   localparam int RAD_W    = 2 * ROOT_W;
   localparam int REM_W    = ROOT_W + 1;
   localparam int CMD_W    = 16;
   localparam int FRAC_SH  = 8;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic signed [YAW_W:0] PI_Q12     = 16'sd12868;
   localparam logic signed [YAW_W:0] NEG_PI_Q12 = -16'sd12868;
   localparam logic signed [YAW_W:0] TWO_PI_Q12 = 16'sd25736;

   localparam logic [1:0] REG_GAIN_LINEAR    = 2'd0;
   localparam logic [1:0] REG_GAIN_ANGULAR   = 2'd1;
   localparam logic [1:0] REG_DISTANCE_LIMIT = 2'd2;
   localparam logic [1:0] REG_ANGLE_LIMIT    = 2'd3;

   localparam logic [GAIN_W-1:0] GAIN_LINEAR_RST    = 12'd256;
   localparam logic [GAIN_W-1:0] GAIN_ANGULAR_RST   = 12'd256;
   localparam logic [DLIM_W-1:0] DISTANCE_LIMIT_RST = 16'd128;
   localparam logic [ALIM_W-1:0] ANGLE_LIMIT_RST    = 14'd2048;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_linear;
      logic [GAIN_W-1:0] gain_angular;
      logic [DLIM_W-1:0] distance_limit;
      logic [ALIM_W-1:0] angle_limit;
   } cfg_type;

   typedef struct packed {
      logic [RAD_W-1:0]        rad;
      logic [REM_W-1:0]        rem;
      logic [ROOT_W-1:0]       root;
      logic signed [ERR_W-1:0] err;
      logic                    goal_valid;
   } sqrt_data_type;

endpackage

`default_nettype wire

// ===== rtl/gtg_front.sv =====
// front end: position differences, heading error wrap, squares and their sum
// uses gtg_pkg; feeds the first square root cell
`default_nettype none

module gtg_front
   import gtg_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic signed [POS_W-1:0] current_x,
   input  wire logic signed [POS_W-1:0] current_y,
   input  wire logic signed [YAW_W-1:0] current_yaw,
   input  wire logic signed [POS_W-1:0] goal_x,
   input  wire logic signed [POS_W-1:0] goal_y,
   input  wire logic signed [YAW_W-1:0] goal_yaw,
   input  wire logic                    goal_valid,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output sqrt_data_type                out_data
);

   logic va_ff, vb_ff, vc_ff;
   logic en_a, en_b, en_c;

   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ERR_W-1:0]  err_a_ff, err_a_in, err_b_ff, err_c_ff;
   logic                     gv_a_ff, gv_b_ff, gv_c_ff;
   logic signed [YAW_W:0]    yaw_diff, yaw_wrap;
   logic signed [2*DIFF_W-1:0] prod_x, prod_y;
   logic [SQ_W-1:0]          sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [RAD_W-1:0]         sum_ff, sum_in;

   assign en_c = !vc_ff || out_ready;
   assign en_b = !vb_ff || en_c;
   assign en_a = !va_ff || en_b;
   assign in_ready = en_a;

   always_comb begin
      dx_in    = DIFF_W'(goal_x) - DIFF_W'(current_x);
      dy_in    = DIFF_W'(goal_y) - DIFF_W'(current_y);
      yaw_diff = (YAW_W+1)'(goal_yaw) - (YAW_W+1)'(current_yaw);
      priority if (yaw_diff > PI_Q12) begin
         yaw_wrap = yaw_diff - TWO_PI_Q12;
      end else if (yaw_diff < NEG_PI_Q12) begin
         yaw_wrap = yaw_diff + TWO_PI_Q12;
      end else begin
         yaw_wrap = yaw_diff;
      end
      err_a_in = yaw_wrap[ERR_W-1:0];
      prod_x   = dx_ff * dx_ff;
      prod_y   = dy_ff * dy_ff;
      sqx_in   = prod_x[SQ_W-1:0];
      sqy_in   = prod_y[SQ_W-1:0];
      sum_in   = RAD_W'(sqx_ff) + RAD_W'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (en_a) va_ff <= in_valid;
         if (en_b) vb_ff <= va_ff;
         if (en_c) vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         err_a_ff <= err_a_in;
         gv_a_ff  <= goal_valid;
      end
      if (en_b) begin
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         err_b_ff <= err_a_ff;
         gv_b_ff  <= gv_a_ff;
      end
      if (en_c) begin
         sum_ff   <= sum_in;
         err_c_ff <= err_b_ff;
         gv_c_ff  <= gv_b_ff;
      end
   end

   assign out_valid = vc_ff;

   always_comb begin
      out_data            = '0;
      out_data.rad        = sum_ff;
      out_data.err        = err_c_ff;
      out_data.goal_valid = gv_c_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/gtg_sqrt_cell.sv =====
// one cell of the square root chain: settles one root bit per request
// uses gtg_pkg; instances are chained in the top level
`default_nettype none

module gtg_sqrt_cell
   import gtg_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire sqrt_data_type  in_data,
   output logic                out_valid,
   input  wire logic           out_ready,
   output sqrt_data_type       out_data
);

   logic          valid_ff;
   logic          en;
   sqrt_data_type data_ff, data_in;
   logic [REM_W+1:0] cand, trial, diff;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      cand    = {in_data.rem, in_data.rad[RAD_W-1 -: 2]};
      trial   = (REM_W+2)'({in_data.root, 2'b01});
      diff    = cand - trial;
      data_in = in_data;
      data_in.rad = {in_data.rad[RAD_W-3:0], 2'b00};
      if (cand >= trial) begin
         data_in.rem  = diff[REM_W-1:0];
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b1};
      end else begin
         data_in.rem  = cand[REM_W-1:0];
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/gtg_back.sv =====
// back end: reach and turn decisions, gain products, saturation, result register
// uses gtg_pkg; takes the distance from the last square root cell
`default_nettype none

module gtg_back
   import gtg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire sqrt_data_type       in_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [CMD_W-1:0]         rsp_linear_cmd,
   output logic signed [CMD_W-1:0]  rsp_angular_cmd,
   output logic                     rsp_goal_reached
);

   localparam int ANG_W = GAIN_W + ERR_W + 1;
   localparam int LIN_W = GAIN_W + ROOT_W;
   localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(32767);
   localparam logic signed [ANG_W-1:0] ANG_MIN = -ANG_W'(32768);

   logic vp_ff, vo_ff, en_p, en_o;
   logic active, turn;
   logic [ERR_W-1:0] abs_err;

   logic signed [ANG_W-1:0] ang_prod_ff, ang_prod_in, ang_shift;
   logic [LIN_W-1:0]        lin_prod_ff, lin_prod_in, lin_shift;
   logic reached_ff, turn_ff, drive_ff;

   logic [CMD_W-1:0]        lin_sat, lin_ff, lin_in;
   logic signed [CMD_W-1:0] ang_sat, ang_ff, ang_in;
   logic                    reach_out_ff;

   assign en_o     = !vo_ff || !rsp_stall;
   assign en_p     = !vp_ff || en_o;
   assign in_ready = en_p;

   always_comb begin
      active      = (in_data.root > ROOT_W'(cfg.distance_limit)) && in_data.goal_valid;
      abs_err     = in_data.err[ERR_W-1] ? ERR_W'(-in_data.err) : ERR_W'(in_data.err);
      turn        = abs_err > ERR_W'(cfg.angle_limit);
      ang_prod_in = $signed({1'b0, cfg.gain_angular}) * in_data.err;
      lin_prod_in = cfg.gain_linear * in_data.root;
   end

   always_comb begin
      ang_shift = ang_prod_ff >>> FRAC_SH;
      lin_shift = lin_prod_ff >> FRAC_SH;
      priority if (ang_shift > ANG_MAX) begin
         ang_sat = CMD_W'(ANG_MAX);
      end else if (ang_shift < ANG_MIN) begin
         ang_sat = CMD_W'(ANG_MIN);
      end else begin
         ang_sat = ang_shift[CMD_W-1:0];
      end
      if (|lin_shift[LIN_W-1:CMD_W]) begin
         lin_sat = '1;
      end else begin
         lin_sat = lin_shift[CMD_W-1:0];
      end
      lin_in = drive_ff ? lin_sat : '0;
      ang_in = turn_ff ? ang_sat : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en_p) vp_ff <= in_valid;
         if (en_o) vo_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_p) begin
         ang_prod_ff <= ang_prod_in;
         lin_prod_ff <= lin_prod_in;
         reached_ff  <= !active;
         turn_ff     <= active && turn;
         drive_ff    <= active && !turn;
      end
      if (en_o) begin
         lin_ff       <= lin_in;
         ang_ff       <= ang_in;
         reach_out_ff <= reached_ff;
      end
   end

   assign rsp_valid        = vo_ff;
   assign rsp_linear_cmd   = lin_ff;
   assign rsp_angular_cmd  = ang_ff;
   assign rsp_goal_reached = reach_out_ff;

endmodule

`default_nettype wire

// ===== rtl/go_to_goal_p_controller_top.sv =====
// Proportional go-to-goal controller. One request per clock cycle is taken
// whenever the result side keeps up; each request yields exactly one result
// after passing three front-end stages for differences, squares and sum,
// seventeen square root cells that settle one distance bit each, and two
// back-end stages for the gain products and saturation. Stalls on the
// result side fill empty stages first, so idle slots are squeezed out before
// req_stall rises. Registers are to be written through the APB-style port
// only while no request is in flight; the block does not enforce this.
// uses gtg_pkg, gtg_front, gtg_sqrt_cell and gtg_back
`default_nettype none

module go_to_goal_p_controller_top
   import gtg_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [POS_W-1:0] req_current_x,
   input  wire logic signed [POS_W-1:0] req_current_y,
   input  wire logic signed [YAW_W-1:0] req_current_yaw,
   input  wire logic signed [POS_W-1:0] req_goal_x,
   input  wire logic signed [POS_W-1:0] req_goal_y,
   input  wire logic signed [YAW_W-1:0] req_goal_yaw,
   input  wire logic                    req_goal_valid,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [CMD_W-1:0]             rsp_linear_cmd,
   output logic signed [CMD_W-1:0]      rsp_angular_cmd,
   output logic                         rsp_goal_reached,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CSR_AW-1:0]       paddr,
   input  wire logic [CSR_DW-1:0]       pwdata,
   output logic [CSR_DW-1:0]            prdata,
   output logic                         pready
);

   cfg_type cfg_ff;
   logic    cfg_write;
   logic [1:0] reg_idx;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_AW-1:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_linear    <= GAIN_LINEAR_RST;
         cfg_ff.gain_angular   <= GAIN_ANGULAR_RST;
         cfg_ff.distance_limit <= DISTANCE_LIMIT_RST;
         cfg_ff.angle_limit    <= ANGLE_LIMIT_RST;
      end else if (cfg_write) begin
         unique case (reg_idx)
            REG_GAIN_LINEAR:    cfg_ff.gain_linear    <= pwdata[GAIN_W-1:0];
            REG_GAIN_ANGULAR:   cfg_ff.gain_angular   <= pwdata[GAIN_W-1:0];
            REG_DISTANCE_LIMIT: cfg_ff.distance_limit <= pwdata[DLIM_W-1:0];
            REG_ANGLE_LIMIT:    cfg_ff.angle_limit    <= pwdata[ALIM_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GAIN_LINEAR:    prdata = CSR_DW'(cfg_ff.gain_linear);
         REG_GAIN_ANGULAR:   prdata = CSR_DW'(cfg_ff.gain_angular);
         REG_DISTANCE_LIMIT: prdata = CSR_DW'(cfg_ff.distance_limit);
         REG_ANGLE_LIMIT:    prdata = CSR_DW'(cfg_ff.angle_limit);
      endcase
   end

   logic          front_ready;
   logic          chain_valid [ROOT_W+1];
   logic          chain_ready [ROOT_W+1];
   sqrt_data_type chain_data  [ROOT_W+1];

   assign req_stall = !front_ready;

   gtg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (front_ready),
      .current_x   (req_current_x),
      .current_y   (req_current_y),
      .current_yaw (req_current_yaw),
      .goal_x      (req_goal_x),
      .goal_y      (req_goal_y),
      .goal_yaw    (req_goal_yaw),
      .goal_valid  (req_goal_valid),
      .out_valid   (chain_valid[0]),
      .out_ready   (chain_ready[0]),
      .out_data    (chain_data[0])
   );

   for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
      gtg_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   gtg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .in_valid         (chain_valid[ROOT_W]),
      .in_ready         (chain_ready[ROOT_W]),
      .in_data          (chain_data[ROOT_W]),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_linear_cmd   (rsp_linear_cmd),
      .rsp_angular_cmd  (rsp_angular_cmd),
      .rsp_goal_reached (rsp_goal_reached)
   );

`ifndef SYNTHESIS
   a_reached_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_goal_reached |-> rsp_linear_cmd == '0 && rsp_angular_cmd == '0)
      else $error("reached result carries a nonzero command");

   a_one_motion: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_linear_cmd == '0 || rsp_angular_cmd == '0)
      else $error("turn and drive commands both nonzero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
